// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the handle table allocator.
// Depends on nothing; a file that asserts provides clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- hw/rtl/thta_pkg.sv -----
// Shared constants for the tagged handle table allocator.
// Depends on nothing; used by thta_cfg and tagged_handle_table_allocator.
package thta_pkg;

	// Table geometry
	localparam int TABLE_SLOTS = 1024;
	localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	// Handle layout: tag in the upper half, slot index in the lower half
	localparam int TAG_W    = 16;
	localparam int HANDLE_W = 32;
	localparam int DATA_W   = 32;

	// Operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes
	localparam int REG_HANDLE_TAG = 0;

endpackage

// ----- hw/rtl/thta_cfg.sv -----
// APB configuration register file of the allocator: holds the handle tag.
// Depends on thta_pkg.
module thta_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [1:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [thta_pkg::TAG_W-1:0]    handle_tag
);

	logic                          wr_en;
	logic [thta_pkg::TAG_W-1:0]    tag_q;

	// Single register at paddr 0: writes decode both paddr bits, reads ignore paddr
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'(thta_pkg::REG_HANDLE_TAG));

	// Hold the tag between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (wr_en) begin
			tag_q <= pwdata[thta_pkg::TAG_W-1:0];
		end
	end

	// Return the tag zero-extended on reads
	assign prdata     = 32'(tag_q);
	assign handle_tag = tag_q;

endmodule

// ----- hw/rtl/tagged_handle_table_allocator.sv -----
// Tagged handle table allocator: slot memory, forward scan from the last hit and command sequencer.
// Depends on thta_pkg, thta_cfg and assert_macros.svh.
// Free and unused op give their result in the cycle after accept, read goes through ST_READ;
// allocate goes through ST_SCAN over k slots, k the number of slots scanned (one slot read per
// cycle from the single memory read port, 1 to TABLE_SLOTS). One item at a time.
// Reset: a clearing pass writes zero to all 1024 slots, one per cycle, busy high.
`include "assert_macros.svh"

module tagged_handle_table_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [thta_pkg::HANDLE_W-1:0]    handle,
	input  logic [thta_pkg::DATA_W-1:0]      user_data,
	output logic                             done,
	output logic                             ok,
	output logic [thta_pkg::HANDLE_W-1:0]    new_handle,
	output logic [thta_pkg::DATA_W-1:0]      read_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [1:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int IW = thta_pkg::IDX_W;
	localparam logic [IW-1:0] LAST_IDX  = IW'(thta_pkg::TABLE_SLOTS - 1);
	localparam logic [16:0]   SLOTS_EXT = 17'(thta_pkg::TABLE_SLOTS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	logic [thta_pkg::TAG_W-1:0]    handle_tag;
	logic [1:0]                    state_q;
	logic [IW-1:0]                 clr_q;
	logic [IW-1:0]                 scan_idx_q;
	logic [IW-1:0]                 search_start_q;
	logic [thta_pkg::DATA_W-1:0]   data_q;
	logic                          rd_ok_q;
	logic                          done_q;
	logic                          ok_q;
	logic [thta_pkg::HANDLE_W-1:0] new_handle_q;
	logic [thta_pkg::DATA_W-1:0]   read_data_q;

	logic [thta_pkg::DATA_W-1:0]   mem [thta_pkg::TABLE_SLOTS];
	logic [thta_pkg::DATA_W-1:0]   rdata_q;

	logic                          accept;
	logic                          in_range;
	logic                          tag_match;
	logic [IW-1:0]                 alloc_start;
	logic                          hit;
	logic                          scan_last;
	logic                          mem_re;
	logic [IW-1:0]                 mem_raddr;
	logic                          mem_we;
	logic [IW-1:0]                 mem_waddr;
	logic [thta_pkg::DATA_W-1:0]   mem_wdata;

	// Configuration registers
	thta_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.handle_tag (handle_tag)
	);

	// Decode the incoming item
	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign in_range    = ({1'b0, handle[15:0]} < SLOTS_EXT);
	assign tag_match   = (handle[31:16] == handle_tag);
	assign alloc_start = (search_start_q == LAST_IDX) ? '0 : search_start_q;
	assign hit         = (state_q == ST_SCAN) && (rdata_q == '0);
	assign scan_last   = (scan_idx_q == LAST_IDX);

	// Select the memory read address
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = alloc_start;
		if (accept && (op == thta_pkg::OP_ALLOC)) begin
			mem_re    = 1'b1;
			mem_raddr = alloc_start;
		end else if (accept && (op == thta_pkg::OP_READ)) begin
			mem_re    = 1'b1;
			mem_raddr = handle[IW-1:0];
		end else if ((state_q == ST_SCAN) && !hit && !scan_last) begin
			mem_re    = 1'b1;
			mem_raddr = scan_idx_q + 1'b1;
		end
	end

	// Select the memory write: clearing pass, free, or allocation hit
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (accept && (op == thta_pkg::OP_FREE) && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = handle[IW-1:0];
		end else if (hit) begin
			mem_we    = 1'b1;
			mem_waddr = scan_idx_q;
			mem_wdata = data_q;
		end
	end

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Sequence the clearing pass, frees, scans and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			scan_idx_q     <= '0;
			search_start_q <= '0;
			rd_ok_q        <= 1'b0;
			done_q         <= 1'b0;
			ok_q           <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op)
							thta_pkg::OP_ALLOC: begin
								search_start_q <= alloc_start;
								scan_idx_q     <= alloc_start;
								state_q        <= ST_SCAN;
							end
							thta_pkg::OP_FREE: begin
								done_q <= 1'b1;
								ok_q   <= in_range;
							end
							thta_pkg::OP_READ: begin
								rd_ok_q <= tag_match && in_range;
								state_q <= ST_READ;
							end
							default: begin
								done_q <= 1'b1;
								ok_q   <= 1'b0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						search_start_q <= scan_idx_q;
						done_q         <= 1'b1;
						ok_q           <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (scan_last) begin
						done_q  <= 1'b1;
						ok_q    <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					ok_q    <= rd_ok_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the allocate data and build result payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q       <= user_data;
			new_handle_q <= '0;
			read_data_q  <= '0;
		end
		if (hit) begin
			new_handle_q <= {handle_tag, 16'(scan_idx_q)};
		end
		if ((state_q == ST_READ) && rd_ok_q) begin
			read_data_q <= rdata_q;
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign new_handle = new_handle_q;
	assign read_data  = read_data_q;

	// Checks
	`ASSERT_NEVER(a_no_done_in_clear, done_q && (state_q == ST_CLEAR), "result during clearing pass")
	`ASSERT_CLK(a_accept_progress, accept |=> (done_q || (state_q != ST_IDLE)), "item neither finished nor in progress")
	`ASSERT_CLK(a_scan_from_start, (state_q == ST_SCAN) |-> (scan_idx_q >= search_start_q), "scan below start index")
	`ASSERT_CLK(a_fail_payload_zero, (done_q && !ok_q) |-> ((new_handle_q == '0) && (read_data_q == '0)), "failed item carries payload")

endmodule
